// ===== src/ilf_pkg.sv =====
// -----------------------------------------------------------------------------
// ilf_pkg
// Shared types and constants for the integer label formatter.
// -----------------------------------------------------------------------------
package ilf_pkg;

   localparam int unsigned LabelCapDefault = 50;

   localparam logic [7:0] ChrPercent = 8'h25;
   localparam logic [7:0] ChrZero    = 8'h30;
   localparam logic [7:0] ChrNine    = 8'h39;
   localparam logic [7:0] ChrSevenH  = 8'h37;
   localparam logic [7:0] ChrMinus   = 8'h4D;
   localparam logic [7:0] ChrDec     = 8'h64;
   localparam logic [7:0] ChrHex     = 8'h78;
   localparam logic [7:0] ChrBlank   = 8'hFF;

   localparam logic [1:0] ModeLiteral = 2'd0;
   localparam logic [1:0] ModeOpen    = 2'd1;
   localparam logic [1:0] ModeWidth   = 2'd2;
   localparam logic [1:0] ModeDrop    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PARSE,
      ST_CONV,
      ST_PREP,
      ST_EMIT,
      ST_MARK
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic parse_upd;
      logic emit_lit;
      logic dabble;
      logic prep;
      logic prep_full;
      logic emit_step;
      logic emit_mark;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic lit_emit;
      logic conv_start;
      logic conv_hex;
      logic item_end;
      logic dabble_done;
      logic label_full;
      logic emit_last;
      logic slot_free;
   } status_type;

endpackage

// ===== src/ilf_ctrl.sv =====
// -----------------------------------------------------------------------------
// ilf_ctrl
// Sequencer: steps each accepted format byte through parse, conversion and
// character emission.
// -----------------------------------------------------------------------------
module ilf_ctrl
   import ilf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type st,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_PARSE;
         end
         ST_PARSE: begin
            if (st.lit_emit) begin
               if (st.slot_free) state_in = ST_IDLE;
            end else if (st.conv_start) begin
               state_in = st.conv_hex ? ST_PREP : ST_CONV;
            end else begin
               state_in = st.item_end ? ST_MARK : ST_IDLE;
            end
         end
         ST_CONV: begin
            if (st.dabble_done) state_in = ST_PREP;
         end
         ST_PREP: begin
            if (st.label_full) begin
               state_in = st.item_end ? ST_MARK : ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (st.slot_free && st.emit_last) state_in = ST_IDLE;
         end
         ST_MARK: begin
            if (st.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_PARSE: begin
            if (st.lit_emit) begin
               cmd.emit_lit = st.slot_free;
            end else begin
               cmd.parse_upd = 1'b1;
            end
         end
         ST_CONV: cmd.dabble = 1'b1;
         ST_PREP: begin
            cmd.prep      = !st.label_full;
            cmd.prep_full = st.label_full;
         end
         ST_EMIT: cmd.emit_step = st.slot_free;
         ST_MARK: cmd.emit_mark = st.slot_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== src/ilf_dpath.sv =====
// -----------------------------------------------------------------------------
// ilf_dpath
// Datapath: parse state, binary-to-BCD converter, emission counters and the
// result register.
// -----------------------------------------------------------------------------
module ilf_dpath
   import ilf_pkg::*;
#(
   parameter int unsigned LABEL_CAPACITY = LabelCapDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  st,
   input  logic [39:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tuser
);

   localparam logic [5:0] Cap     = 6'(LABEL_CAPACITY);
   localparam logic [5:0] CapLast = 6'(LABEL_CAPACITY - 1);

   // item registers
   logic [7:0]  chr_ff;
   logic [31:0] val_ff;
   logic        end_ff;

   // label state
   logic [1:0]  mode_ff, mode_in;
   logic [5:0]  width_ff, width_in;
   logic        zpad_ff, zpad_in;
   logic [5:0]  count_ff, count_in;
   logic        ovf_ff, ovf_in;

   // conversion
   logic [31:0] bin_ff, bin_in;
   logic [39:0] bcd_ff, bcd_in;
   logic [4:0]  bit_ff, bit_in;
   logic        neg_ff, neg_in;
   logic [5:0]  pads_ff, total_ff, k_ff, k_in;
   logic        fovf_ff;

   // result register
   logic        ov_ff, ov_in;
   logic        ohas_ff, odone_ff, oovf_ff;
   logic [7:0]  ochr_ff;
   logic [5:0]  oidx_ff, olen_ff;

   logic        is_digit, is_conv, slot_free, clr;
   logic [9:0]  wsum;
   logic [31:0] mag;
   logic [39:0] bcd_adj;
   logic [3:0]  nd;
   logic [5:0]  pads_c, total_c;
   logic [6:0]  sum_c;
   logic [3:0]  didx, dig;
   logic [7:0]  step_chr;
   logic        e_has, e_done, e_ovf;
   logic [7:0]  e_chr;
   logic [5:0]  e_idx, e_len;

   assign is_digit  = (chr_ff >= ChrZero) && (chr_ff <= ChrNine);
   assign is_conv   = (mode_ff == ModeOpen || mode_ff == ModeWidth) &&
                      (chr_ff == ChrDec || chr_ff == ChrHex);
   assign slot_free = !ov_ff || rsp_tready;
   assign wsum      = 10'(width_ff) * 10'd10 + 10'(chr_ff - ChrZero);
   assign mag       = val_ff[31] ? (32'd0 - val_ff) : val_ff;

   // status
   always_comb begin
      st.lit_emit    = (mode_ff == ModeLiteral) && (chr_ff != ChrPercent) &&
                       (count_ff < Cap);
      st.conv_start  = is_conv;
      st.conv_hex    = (chr_ff == ChrHex);
      st.item_end    = end_ff;
      st.dabble_done = (bit_ff == 5'd31);
      st.label_full  = (count_ff >= Cap);
      st.emit_last   = (k_ff == total_ff - 6'd1) || (count_ff == CapLast);
      st.slot_free   = slot_free;
   end

   // add-3 correction on every BCD digit
   always_comb begin
      bcd_adj = bcd_ff;
      for (int i = 0; i < 10; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
      end
   end

   // digit count: highest non-zero digit, at least one
   always_comb begin
      nd = 4'd1;
      for (int i = 1; i < 10; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) nd = 4'(i + 1);
      end
   end

   // padding and sequence length for the conversion
   always_comb begin
      pads_c = 6'd0;
      if (width_ff > 6'(nd)) pads_c = width_ff - 6'(nd) - 6'(neg_ff);
      total_c = pads_c + 6'(neg_ff) + 6'(nd);
      sum_c   = 7'(count_ff) + 7'(total_c);
   end

   // character for the current emission step
   always_comb begin
      didx = 4'(total_ff - 6'd1 - k_ff);
      dig  = bcd_ff[didx*4 +: 4];
      if (k_ff < pads_ff) begin
         step_chr = zpad_ff ? ChrZero : ChrBlank;
      end else if (neg_ff && k_ff == pads_ff) begin
         step_chr = ChrMinus;
      end else if (dig < 4'd10) begin
         step_chr = ChrZero + 8'(dig);
      end else begin
         step_chr = ChrSevenH + 8'(dig);
      end
   end

   // label state updates
   always_comb begin
      mode_in  = mode_ff;
      width_in = width_ff;
      zpad_in  = zpad_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      bit_in   = bit_ff;
      neg_in   = neg_ff;
      k_in     = k_ff;
      clr      = 1'b0;
      if (cmd.parse_upd) begin
         case (mode_ff)
            ModeLiteral: begin
               if (chr_ff == ChrPercent) begin
                  mode_in  = ModeOpen;
                  width_in = 6'd0;
                  zpad_in  = 1'b0;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            ModeOpen, ModeWidth: begin
               if (is_digit) begin
                  if (mode_ff == ModeOpen && chr_ff == ChrZero) zpad_in = 1'b1;
                  width_in = (wsum > 10'd63) ? 6'd63 : wsum[5:0];
                  mode_in  = ModeWidth;
               end else if (is_conv) begin
                  mode_in = ModeLiteral;
                  neg_in  = val_ff[31] && (val_ff != 32'd0);
                  bit_in  = 5'd0;
                  if (chr_ff == ChrHex) begin
                     bcd_in = {8'd0, mag};
                  end else begin
                     bcd_in = '0;
                     bin_in = mag;
                  end
               end else begin
                  mode_in = ModeDrop;
               end
            end
            default: mode_in = mode_ff;
         endcase
         clr = end_ff && !is_conv && !(mode_ff == ModeLiteral && chr_ff != ChrPercent);
         clr = 1'b0;
      end
      if (cmd.dabble) begin
         {bcd_in, bin_in} = {bcd_adj[38:0], bin_ff, 1'b0};
         bit_in = bit_ff + 5'd1;
      end
      if (cmd.prep) k_in = 6'd0;
      if (cmd.prep_full) ovf_in = 1'b1;
      if (cmd.emit_lit) begin
         count_in = count_ff + 6'd1;
         clr      = end_ff;
      end
      if (cmd.emit_step) begin
         count_in = count_ff + 6'd1;
         k_in     = k_ff + 6'd1;
         if (st.emit_last) begin
            ovf_in = fovf_ff;
            clr    = end_ff;
         end
      end
      if (cmd.emit_mark) clr = 1'b1;
      if (clr) begin
         mode_in  = ModeLiteral;
         width_in = 6'd0;
         zpad_in  = 1'b0;
         count_in = 6'd0;
         ovf_in   = 1'b0;
      end
   end

   // result beat contents
   always_comb begin
      e_has  = 1'b1;
      e_chr  = chr_ff;
      e_idx  = count_ff;
      e_done = end_ff;
      e_len  = count_ff + 6'd1;
      e_ovf  = ovf_ff;
      if (cmd.emit_step) begin
         e_chr  = step_chr;
         e_done = end_ff && st.emit_last;
         e_ovf  = fovf_ff;
      end else if (cmd.emit_mark) begin
         e_has  = 1'b0;
         e_chr  = 8'd0;
         e_idx  = 6'd0;
         e_done = 1'b1;
         e_len  = count_ff;
      end
      if (!e_done) begin
         e_len = 6'd0;
         e_ovf = 1'b0;
      end
   end

   assign ov_in = (cmd.emit_lit || cmd.emit_step || cmd.emit_mark) ? 1'b1 :
                  (rsp_tready ? 1'b0 : ov_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ModeLiteral;
         width_ff <= 6'd0;
         zpad_ff  <= 1'b0;
         count_ff <= 6'd0;
         ovf_ff   <= 1'b0;
         bit_ff   <= 5'd0;
         k_ff     <= 6'd0;
         ov_ff    <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         width_ff <= width_in;
         zpad_ff  <= zpad_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         bit_ff   <= bit_in;
         k_ff     <= k_in;
         ov_ff    <= ov_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         chr_ff <= req_tdata[7:0];
         val_ff <= req_tdata[39:8];
         end_ff <= req_tlast;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      if (cmd.prep) begin
         pads_ff  <= pads_c;
         total_ff <= total_c;
         fovf_ff  <= ovf_ff || (sum_c > 7'(Cap));
      end
      if (cmd.emit_lit || cmd.emit_step || cmd.emit_mark) begin
         ohas_ff  <= e_has;
         ochr_ff  <= e_chr;
         oidx_ff  <= e_idx;
         odone_ff <= e_done;
         olen_ff  <= e_len;
         oovf_ff  <= e_ovf;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {3'd0, oovf_ff, olen_ff, oidx_ff, ochr_ff};
   assign rsp_tlast  = odone_ff;
   assign rsp_tuser  = ohas_ff;

endmodule

// ===== src/integer_label_formatter.sv =====
// -----------------------------------------------------------------------------
// integer_label_formatter
// Expands a format string with %d / %x conversions into label characters.
// -----------------------------------------------------------------------------
// One format byte is taken at a time and worked on alone. A %x conversion
// goes straight to set-up, a %d conversion first runs a 32-step
// shift-and-add-3 binary-to-decimal converter; then one character is
// emitted per cycle, set by the single result register, while the result
// side is ready. A bare end marker adds one result beat with no character.
module integer_label_formatter
   import ilf_pkg::*;
#(
   parameter int unsigned LABEL_CAPACITY = LabelCapDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // fmt_char[7:0], value[39:8]
   input  logic        req_tlast,   // label_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_char[7:0], char_index[13:8],
                                    // label_length[19:14], overflowed[20]
   output logic        rsp_tlast,   // label_done
   output logic        rsp_tuser    // has_char
);

   cmd_type    cmd;
   status_type st;

   ilf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   ilf_dpath #(
      .LABEL_CAPACITY (LABEL_CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for integer_label_formatter: format-byte beats are
// driven with random gaps, every result beat is checked against a predicted
// label character stream held in a queue.
// -----------------------------------------------------------------------------
module testbench
   import ilf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Cap = 50;
   localparam int WatchLimit = 40000;

   typedef struct packed {
      logic [7:0]  fmt_char;
      logic [31:0] value;
      logic        label_end;
   } fmt_beat_type;

   typedef struct packed {
      logic       has_char;
      logic [7:0] out_char;
      logic [5:0] char_index;
      logic       label_done;
      logic [5:0] label_length;
      logic       overflowed;
   } label_char_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   fmt_beat_type   pending_beats[$];
   label_char_type expected_chars[$];
   int             error_count;
   bit             hold_off_req;

   // formatter state mirror
   logic [1:0] fm_mode;
   int         fm_width;
   bit         fm_zpad;
   int         fm_count;
   bit         fm_ovf;

   integer_label_formatter DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   function automatic void fmt_clear();
      fm_mode = ModeLiteral;
      fm_width = 0;
      fm_zpad = 0;
      fm_count = 0;
      fm_ovf = 0;
   endfunction

   function automatic void push_label_char(input logic [7:0] ch, inout int produced);
      label_char_type r;
      if (fm_count < Cap) begin
         r = '0;
         r.has_char = 1'b1;
         r.out_char = ch;
         r.char_index = fm_count[5:0];
         expected_chars.push_back(r);
         produced++;
         fm_count++;
      end else begin
         fm_ovf = 1;
      end
   endfunction

   function automatic void expand_conversion(input logic [31:0] raw, input bit hex,
                                             inout int produced);
      logic [3:0]  digs[12];
      int          nd, pads, base;
      bit          neg;
      logic [31:0] mag;
      logic [7:0]  pad;
      nd = 0;
      pads = 0;
      base = hex ? 16 : 10;
      neg = raw[31];
      mag = neg ? -raw : raw;
      pad = fm_zpad ? ChrZero : ChrBlank;
      if (mag == 0) begin
         digs[0] = 0;
         nd = 1;
         neg = 0;
      end else begin
         while (mag != 0) begin
            digs[nd] = 4'(mag % base);
            mag = mag / base;
            nd++;
         end
      end
      if (fm_width > nd) begin
         pads = fm_width - nd;
         if (neg) pads--;
      end
      for (int i = 0; i < pads; i++) push_label_char(pad, produced);
      if (neg) push_label_char(ChrMinus, produced);
      while (nd > 0) begin
         nd--;
         push_label_char(digs[nd] < 10 ? ChrZero + digs[nd] : ChrSevenH + digs[nd],
                         produced);
      end
   endfunction

   // predict the result beats caused by one accepted format beat
   function automatic void predict_format(input fmt_beat_type b);
      int produced;
      int w;
      label_char_type r;
      produced = 0;
      case (fm_mode)
         ModeLiteral: begin
            if (b.fmt_char == ChrPercent) begin
               fm_mode = ModeOpen;
               fm_width = 0;
               fm_zpad = 0;
            end else begin
               push_label_char(b.fmt_char, produced);
            end
         end
         ModeOpen, ModeWidth: begin
            if (b.fmt_char >= ChrZero && b.fmt_char <= ChrNine) begin
               if (fm_mode == ModeOpen && b.fmt_char == ChrZero) fm_zpad = 1;
               w = fm_width * 10 + (b.fmt_char - ChrZero);
               fm_width = w > 63 ? 63 : w;
               fm_mode = ModeWidth;
            end else if (b.fmt_char == ChrDec || b.fmt_char == ChrHex) begin
               expand_conversion(b.value, b.fmt_char == ChrHex, produced);
               fm_mode = ModeLiteral;
            end else begin
               fm_mode = ModeDrop;
            end
         end
         default: ;
      endcase
      if (b.label_end) begin
         if (produced == 0) begin
            r = '0;
            expected_chars.push_back(r);
         end
         r = expected_chars.pop_back();
         r.label_done = 1'b1;
         r.label_length = fm_count[5:0];
         r.overflowed = fm_ovf;
         expected_chars.push_back(r);
         fmt_clear();
      end
   endfunction

   // driver: one beat at a time with a random gap before each
   int gap_req;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_req <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else if (gap_req > 0) begin
         req_tvalid <= 1'b0;
         gap_req <= gap_req - 1;
      end else if (pending_beats.size() > 0) begin
         fmt_beat_type b;
         b = pending_beats.pop_front();
         req_tvalid <= 1'b1;
         req_tdata <= {b.value, b.fmt_char};
         req_tlast <= b.label_end;
         gap_req <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 6);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // prediction on accept
   always @(posedge clock) begin
      fmt_beat_type b;
      if (!reset && req_tvalid && req_tready) begin
         b.fmt_char = req_tdata[7:0];
         b.value = req_tdata[39:8];
         b.label_end = req_tlast;
         predict_format(b);
      end
   end

   // monitor: random ready, checks every accepted result beat
   int gap_rsp;
   int long_hold;
   always @(posedge clock) begin
      label_char_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         gap_rsp <= 0;
         long_hold <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata[7:0], 0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tuser !== want.has_char)
                  report_mismatch("has_char", rsp_tuser, want.has_char);
               if (rsp_tdata[7:0] !== want.out_char)
                  report_mismatch("out_char", rsp_tdata[7:0], want.out_char);
               if (rsp_tdata[13:8] !== want.char_index)
                  report_mismatch("char_index", rsp_tdata[13:8], want.char_index);
               if (rsp_tlast !== want.label_done)
                  report_mismatch("label_done", rsp_tlast, want.label_done);
               if (rsp_tdata[19:14] !== want.label_length)
                  report_mismatch("label_length", rsp_tdata[19:14], want.label_length);
               if (rsp_tdata[20] !== want.overflowed)
                  report_mismatch("overflowed", rsp_tdata[20], want.overflowed);
            end
         end
         if (hold_off_req && long_hold == 0) begin
            long_hold <= 400;
            rsp_tready <= 1'b0;
         end else if (long_hold > 1) begin
            long_hold <= long_hold - 1;
            rsp_tready <= 1'b0;
         end else if (long_hold == 1) begin
            long_hold <= -1;
            rsp_tready <= 1'b1;
         end else if (gap_rsp > 0) begin
            gap_rsp <= gap_rsp - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               gap_rsp <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 6);
         end
      end
   end

   // watchdog on cycles with no accepted beat
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic add_beat(input logic [7:0] c, input logic [31:0] v, input bit e);
      fmt_beat_type b;
      b.fmt_char = c;
      b.value = v;
      b.label_end = e;
      pending_beats.push_back(b);
   endtask

   task automatic add_text(input string s, input logic [31:0] v);
      for (int i = 0; i < s.len(); i++) add_beat(s[i], v, i == s.len() - 1);
   endtask

   // random byte biased towards format syntax
   function automatic logic [7:0] pick_fmt_char(input int mode);
      int k;
      k = $urandom_range(0, 9);
      if (mode == 1 && k < 3) return 8'(ChrZero + $urandom_range(0, 9));
      if (mode == 1 && k < 6) return $urandom_range(0, 1) ? ChrDec : ChrHex;
      if (k == 0) return ChrPercent;
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      int n;
      logic [31:0] v;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      error_count = 0;
      hold_off_req = 0;
      fmt_clear();

      // directed labels
      add_text("%d", 32'd0);
      add_text("A%8d", 32'h8000_0000);
      add_text("%05x", 32'hFFFF_FFFF);
      add_text("%x%d", 32'h7FFF_FFFF);
      add_text("%99d", 32'd1234);
      add_text("%q7", 32'd5);
      add_text("%%d", 32'd5);
      add_text("ab%1", 32'd5);
      add_beat(8'h00, 32'd0, 1);
      add_beat(8'hFF, 32'd0, 1);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // random labels, mostly well formed
      repeat (13) begin
         v = $urandom;
         if ($urandom_range(0, 7) == 0) v = 32'h8000_0000;
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) != 0) begin
               add_beat(ChrPercent, v, 0);
               if ($urandom_range(0, 1)) add_beat(ChrZero, v, 0);
               if ($urandom_range(0, 1))
                  add_beat(8'(ChrZero + $urandom_range(1, 9)), v, 0);
               if ($urandom_range(0, 9) == 0) add_beat(pick_fmt_char(0), v, 0);
               add_beat($urandom_range(0, 1) ? ChrDec : ChrHex, v, i == n - 1);
            end else begin
               add_beat(pick_fmt_char(0), v, i == n - 1);
            end
         end
         if (pending_beats.size() > 60) hold_off_req = 1;
      end

      // drain: every beat sent, accepted and its results checked
      while (pending_beats.size() != 0 || req_tvalid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
